FILE: sv/lsms_pkg.sv
// Shared types, constants and microcode ROM of the load/store-multiple sequencer.
`default_nettype none

package lsms_pkg;

    localparam int LIST_W = 16;
    localparam int CNT_W  = 5;
    localparam int ADDR_W = 32;
    localparam int DATA_W = 40;

    localparam logic [3:0]        PC_INDEX   = 4'd15;
    localparam logic [ADDR_W-1:0] PC_OFFSET  = 32'd8;
    localparam logic [ADDR_W-1:0] WORD_BYTES = 32'd4;

    typedef logic [1:0] step_t;
    typedef logic [1:0] wait_t;
    typedef logic [1:0] branch_t;

    localparam step_t STEP_IDLE  = 2'd0;
    localparam step_t STEP_SETUP = 2'd1;
    localparam step_t STEP_XFER  = 2'd2;
    localparam step_t STEP_WB    = 2'd3;

    localparam wait_t WAIT_NONE = 2'd0;
    localparam wait_t WAIT_IN   = 2'd1;
    localparam wait_t WAIT_OUT  = 2'd2;

    localparam branch_t BR_NONE       = 2'd0;
    localparam branch_t BR_LIST_EMPTY = 2'd1;
    localparam branch_t BR_NO_WB      = 2'd2;

    localparam logic KIND_XFER   = 1'b0;
    localparam logic KIND_UPDATE = 1'b1;

    typedef struct packed {
        wait_t   wait_on;
        branch_t branch_on;
        step_t   br_target;
        logic    take_in;
        logic    setup;
        logic    emit_xfer;
        logic    emit_wb;
        step_t   target;
    } ucode_t;

    // The branch is tested first; otherwise the step waits for its
    // condition, performs its actions and moves to its target.
    function automatic ucode_t ucode_rom(input step_t step);
        ucode_t w;
        w = '0;
        case (step)
            STEP_IDLE: begin
                w.wait_on = WAIT_IN;
                w.take_in = 1'b1;
                w.target  = STEP_SETUP;
            end
            STEP_SETUP: begin
                w.wait_on = WAIT_NONE;
                w.setup   = 1'b1;
                w.target  = STEP_XFER;
            end
            STEP_XFER: begin
                w.branch_on = BR_LIST_EMPTY;
                w.br_target = STEP_WB;
                w.wait_on   = WAIT_OUT;
                w.emit_xfer = 1'b1;
                w.target    = STEP_XFER;
            end
            STEP_WB: begin
                w.branch_on = BR_NO_WB;
                w.br_target = STEP_IDLE;
                w.wait_on   = WAIT_OUT;
                w.emit_wb   = 1'b1;
                w.target    = STEP_IDLE;
            end
            default: begin
                w.target = STEP_IDLE;
            end
        endcase
        return w;
    endfunction

    function automatic logic [CNT_W-1:0] popcount16(input logic [LIST_W-1:0] v);
        logic [CNT_W-1:0] c;
        c = '0;
        for (int i = 0; i < LIST_W; i++) begin
            c = c + CNT_W'(v[i]);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

FILE: sv/load_store_multiple_sequencer.sv
// Sequence: the accepting step is followed by a setup step that loads the start address, then
// by the transfer steps, each of which registers one result.
// An instruction holds the sequencer through accept, setup, one result per transfer step,
// the end-of-list test and the update step; a stalled result port holds it longer, and a new
// instruction is accepted only after the sequencer is back in idle.
// Reset: aresetn, synchronous, active low, returns the step counter to idle and clears valid.
`default_nettype none

module load_store_multiple_sequencer
    import lsms_pkg::*;
#(
    parameter int NUM_REGS = 16
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    // s_tdata, low bit up: base_value[31:0], base_reg[35:32], reg_list[51:36],
    // is_load[52], ascending[53], start_at_base[54], update_base[55]
    input  wire logic [55:0]       s_tdata,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    // m_tdata, low bit up: reg_index[3:0], address[35:4], load_access[36],
    // add_eight[37], zero padding[39:38]
    output logic [DATA_W-1:0]      m_tdata,
    // m_tuser: kind[0]
    output logic                   m_tuser,
    output logic                   m_tlast,
    output logic                   m_tvalid,
    input  wire logic              m_tready
);

    localparam int MASK_BITS = (NUM_REGS < LIST_W) ? NUM_REGS : LIST_W;
    localparam logic [LIST_W:0] MASK_FULL = (17'd1 << MASK_BITS) - 17'd1;
    localparam logic [LIST_W-1:0] LIST_MASK = MASK_FULL[LIST_W-1:0];

    // Input field views
    logic [ADDR_W-1:0] in_base;
    logic [3:0]        in_breg;
    logic [LIST_W-1:0] in_list;
    assign in_base = s_tdata[31:0];
    assign in_breg = s_tdata[35:32];
    assign in_list = s_tdata[51:36] & LIST_MASK;

    step_t             step_reg, step_next;
    logic [ADDR_W-1:0] eff_base_reg;
    logic [3:0]        breg_reg;
    logic [LIST_W-1:0] list_reg;
    logic [CNT_W-1:0]  n_reg;
    logic              load_reg, asc_reg, atb_reg, wb_reg;
    logic [ADDR_W-1:0] xfer_addr_reg;

    logic              out_valid_reg;
    logic              out_kind_reg, out_last_reg, out_load_reg, out_add8_reg;
    logic [3:0]        out_idx_reg;
    logic [ADDR_W-1:0] out_addr_reg;

    ucode_t            uc;
    logic              out_free;
    logic              branch_taken;
    logic              wait_ok;
    logic              fire;
    logic [ADDR_W-1:0] n4;
    logic [ADDR_W-1:0] dec_mag;
    logic [ADDR_W-1:0] start_addr;
    logic [ADDR_W-1:0] new_base;
    logic [3:0]        low_idx;
    logic [LIST_W-1:0] list_clr;

    assign uc       = ucode_rom(step_reg);
    assign out_free = !out_valid_reg || m_tready;

    always_comb begin
        case (uc.branch_on)
            BR_LIST_EMPTY: branch_taken = (list_reg == '0);
            BR_NO_WB:      branch_taken = !wb_reg;
            default:       branch_taken = 1'b0;
        endcase
        case (uc.wait_on)
            WAIT_IN:  wait_ok = s_tvalid;
            WAIT_OUT: wait_ok = out_free;
            default:  wait_ok = 1'b1;
        endcase
    end

    assign fire     = !branch_taken && wait_ok;
    assign s_tready = uc.take_in;

    always_comb begin
        if (branch_taken) begin
            step_next = uc.br_target;
        end else if (wait_ok) begin
            step_next = uc.target;
        end else begin
            step_next = step_reg;
        end
    end

    // Address arithmetic: 4n is a shift of the register count.
    assign n4         = {{(ADDR_W-CNT_W-2){1'b0}}, n_reg, 2'b00};
    assign dec_mag    = atb_reg ? (n4 - WORD_BYTES) : n4;
    assign start_addr = asc_reg ? (eff_base_reg + (atb_reg ? '0 : WORD_BYTES))
                                : (eff_base_reg - dec_mag);
    assign new_base   = asc_reg ? (eff_base_reg + n4) : (eff_base_reg - n4);

    always_comb begin
        low_idx = '0;
        for (int i = LIST_W - 1; i >= 0; i--) begin
            if (list_reg[i]) begin
                low_idx = 4'(i);
            end
        end
    end

    assign list_clr = list_reg & (list_reg - 16'd1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= STEP_IDLE;
        end else begin
            step_reg <= step_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire && uc.take_in) begin
            eff_base_reg <= (in_breg == PC_INDEX) ? (in_base + PC_OFFSET) : in_base;
            breg_reg     <= in_breg;
            list_reg     <= in_list;
            n_reg        <= popcount16(in_list);
            load_reg     <= s_tdata[52];
            asc_reg      <= s_tdata[53];
            atb_reg      <= s_tdata[54];
            wb_reg       <= s_tdata[55];
        end else if (fire && uc.emit_xfer) begin
            list_reg <= list_clr;
        end
        if (fire && uc.setup) begin
            xfer_addr_reg <= start_addr;
        end else if (fire && uc.emit_xfer) begin
            xfer_addr_reg <= xfer_addr_reg + WORD_BYTES;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (fire && (uc.emit_xfer || uc.emit_wb)) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire && uc.emit_xfer) begin
            out_kind_reg <= KIND_XFER;
            out_idx_reg  <= low_idx;
            out_addr_reg <= xfer_addr_reg;
            out_load_reg <= load_reg;
            out_add8_reg <= !load_reg && (low_idx == PC_INDEX);
            out_last_reg <= (list_clr == '0) && !wb_reg;
        end else if (fire && uc.emit_wb) begin
            out_kind_reg <= KIND_UPDATE;
            out_idx_reg  <= breg_reg;
            out_addr_reg <= new_base;
            out_load_reg <= 1'b0;
            out_add8_reg <= 1'b0;
            out_last_reg <= 1'b1;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {2'b00, out_add8_reg, out_load_reg, out_addr_reg, out_idx_reg};

endmodule

`default_nettype wire

FILE: sv/lsms_checker.sv
// Port-level checker for the load/store-multiple sequencer and its bind.
`default_nettype none

module lsms_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic [39:0] m_tdata,
    input wire logic        m_tuser,
    input wire logic        m_tlast,
    input wire logic        m_tvalid,
    input wire logic        m_tready
);

    // A result held back by the consumer stays offered.
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result valid dropped while stalled");

    // Only one instruction is in work at a time.
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second item taken while busy");

    // The base update always closes its instruction.
    a_update_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tlast && !m_tdata[36] && !m_tdata[37])
        else $error("base update not marked last or carries access flags");

    // The add-eight mark belongs only to a store of the program counter.
    a_add_eight: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[37] |-> m_tdata[3:0] == 4'hf && !m_tdata[36] && !m_tuser)
        else $error("add-eight mark on a wrong result");

    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind load_store_multiple_sequencer lsms_checker u_lsms_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);

`default_nettype wire

FILE: sim/tb.sv
// Self-checking testbench for the load/store-multiple address sequencer.
`default_nettype none

module tb;
    import lsms_pkg::*;

    typedef struct {
        logic        kind;
        logic [3:0]  reg_index;
        logic [31:0] address;
        logic        load_access;
        logic        add_eight;
        logic        last;
    } xfer_result_t;

    // Predicts the transfer commands and base update of each accepted
    // instruction and matches them against the sequencer output in order.
    class xfer_scoreboard;
        xfer_result_t pending_xfers[$];
        int n_instr;
        int n_xfer;
        int n_update;
        int n_empty;
        int n_errors;

        function void note_instruction(logic [55:0] instr);
            logic [31:0] base;
            logic [3:0]  breg;
            logic [15:0] list;
            logic        load;
            logic        asc;
            logic        at_base;
            logic        wb;
            logic [31:0] addr;
            int          count;
            int          total;
            int          k;
            xfer_result_t r;
            base    = instr[31:0];
            breg    = instr[35:32];
            list    = instr[51:36];
            load    = instr[52];
            asc     = instr[53];
            at_base = instr[54];
            wb      = instr[55];
            count   = 0;
            for (int i = 0; i < LIST_W; i++) begin
                if (list[i]) count++;
            end
            // The program counter reads two instructions ahead.
            if (breg == PC_INDEX) base = base + PC_OFFSET;
            if (asc) begin
                addr = at_base ? base : base + WORD_BYTES;
            end else begin
                addr = base - WORD_BYTES * 32'(count);
                if (at_base) addr = addr + WORD_BYTES;
            end
            total = count + int'(wb);
            k = 0;
            for (int i = 0; i < LIST_W; i++) begin
                if (list[i]) begin
                    r.kind        = KIND_XFER;
                    r.reg_index   = 4'(i);
                    r.address     = addr;
                    r.load_access = load;
                    r.add_eight   = !load && (4'(i) == PC_INDEX);
                    r.last        = (k + 1 == total);
                    pending_xfers.push_back(r);
                    addr = addr + WORD_BYTES;
                    k++;
                end
            end
            if (wb) begin
                r.kind        = KIND_UPDATE;
                r.reg_index   = breg;
                r.address     = asc ? base + WORD_BYTES * 32'(count)
                                    : base - WORD_BYTES * 32'(count);
                r.load_access = 1'b0;
                r.add_eight   = 1'b0;
                r.last        = 1'b1;
                pending_xfers.push_back(r);
            end
            n_instr++;
            if (total == 0) n_empty++;
        endfunction

        function void compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
            if (exp_v !== act_v) begin
                $display("%0t: %s mismatch, expected %h, actual %h",
                         $time, name, exp_v, act_v);
                n_errors++;
            end
        endfunction

        function void check_output(logic kind, logic [DATA_W-1:0] data, logic last);
            xfer_result_t e;
            if (pending_xfers.size() == 0) begin
                $display("%0t: unexpected item, expected none, actual kind %b data %h last %b",
                         $time, kind, data, last);
                n_errors++;
                return;
            end
            e = pending_xfers.pop_front();
            compare_field("kind", 32'(e.kind), 32'(kind));
            compare_field("reg_index", 32'(e.reg_index), 32'(data[3:0]));
            compare_field("address", e.address, data[35:4]);
            compare_field("load_access", 32'(e.load_access), 32'(data[36]));
            compare_field("add_eight", 32'(e.add_eight), 32'(data[37]));
            compare_field("padding", 32'(0), 32'(data[39:38]));
            compare_field("last", 32'(e.last), 32'(last));
            if (kind == KIND_UPDATE) n_update++;
            else n_xfer++;
        endfunction
    endclass

    logic              aclk;
    logic              aresetn;
    logic [55:0]       s_tdata;
    logic              s_tvalid;
    logic              s_tready;
    logic [DATA_W-1:0] m_tdata;
    logic              m_tuser;
    logic              m_tlast;
    logic              m_tvalid;
    logic              m_tready;

    logic s_idle_on;
    logic m_idle_on;
    int   m_stall_left;

    xfer_scoreboard sb = new();

    load_store_multiple_sequencer u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #10_000_000;
        $display("Timeout with %0d results still outstanding.", sb.pending_xfers.size());
        $display("FAILURE");
        $finish;
    end

    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) sb.note_instruction(s_tdata);
        if (aresetn && m_tvalid && m_tready) sb.check_output(m_tuser, m_tdata, m_tlast);
    end

    // Result side: ready drops in random bursts while stalling is enabled.
    initial begin
        m_tready = 1'b0;
        m_stall_left = 0;
        forever begin
            @(negedge aclk);
            if (m_stall_left > 0) begin
                m_tready = 1'b0;
                m_stall_left--;
            end else if (m_idle_on && $urandom_range(0, 5) == 0) begin
                m_tready = 1'b0;
                m_stall_left = $urandom_range(1, 17) - 1;
            end else begin
                m_tready = 1'b1;
            end
        end
    end

    function automatic logic [55:0] pack_instr(logic [31:0] base, logic [3:0] breg,
                                               logic [15:0] list, logic load, logic asc,
                                               logic at_base, logic wb);
        return {wb, at_base, asc, load, list, breg, base};
    endfunction

    // Called and returns at a falling edge; valid stays high for the next item.
    task automatic send_instr(logic [55:0] instr);
        int gap;
        if (s_idle_on && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 17);
            repeat (gap) begin
                s_tvalid = 1'b0;
                s_tdata  = 56'({$urandom, $urandom});
                @(negedge aclk);
            end
        end
        s_tvalid = 1'b1;
        s_tdata  = instr;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    initial begin
        logic [31:0] base;
        logic [15:0] list;
        logic [3:0]  flags;
        int          n_rand;

        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_idle_on = 1'b0;
        m_idle_on = 1'b0;
        repeat (6) @(negedge aclk);
        aresetn = 1'b1;

        // Directed: field extremes, every mode, wrapping addresses, PC cases.
        send_instr(pack_instr(32'h0000_0000, 4'd0, 16'h0001, 1'b1, 1'b1, 1'b1, 1'b0));
        send_instr(pack_instr(32'hFFFF_FFFF, 4'd15, 16'hFFFF, 1'b0, 1'b1, 1'b0, 1'b1));
        send_instr(pack_instr(32'h0000_0000, 4'd15, 16'hFFFF, 1'b0, 1'b0, 1'b1, 1'b1));
        send_instr(pack_instr(32'h0000_1000, 4'd13, 16'h0000, 1'b1, 1'b1, 1'b0, 1'b1));
        send_instr(pack_instr(32'h0000_1000, 4'd13, 16'h0000, 1'b0, 1'b0, 1'b0, 1'b0));
        send_instr(pack_instr(32'h2000_0000, 4'd2, 16'h8000, 1'b1, 1'b1, 1'b1, 1'b1));
        send_instr(pack_instr(32'h2000_0000, 4'd2, 16'h8000, 1'b0, 1'b0, 1'b0, 1'b0));
        send_instr(pack_instr(32'h8000_0000, 4'd1, 16'hAAAA, 1'b1, 1'b0, 1'b1, 1'b1));
        send_instr(pack_instr(32'h7FFF_FFFC, 4'd14, 16'h5555, 1'b0, 1'b1, 1'b0, 1'b1));
        send_instr(pack_instr(32'hFFFF_FFF8, 4'd15, 16'h0000, 1'b0, 1'b0, 1'b1, 1'b1));
        send_instr(pack_instr(32'h0000_0004, 4'd0, 16'h0001, 1'b1, 1'b1, 1'b1, 1'b1));
        send_instr(pack_instr(32'h0000_0004, 4'd7, 16'hFFFF, 1'b1, 1'b0, 1'b0, 1'b1));
        send_instr(pack_instr(32'hFFFF_FFFC, 4'd15, 16'h8001, 1'b0, 1'b1, 1'b1, 1'b0));
        send_instr(pack_instr(32'h1234_5678, 4'd9, 16'h0000, 1'b1, 1'b0, 1'b1, 1'b0));
        send_instr(pack_instr(32'hDEAD_BEEC, 4'd15, 16'h7FFF, 1'b1, 1'b0, 1'b0, 1'b0));
        send_instr(pack_instr(32'h0000_0010, 4'd3, 16'hC000, 1'b0, 1'b0, 1'b1, 1'b0));

        n_rand = 470;
        for (int i = 0; i < n_rand; i++) begin
            // Alternate stretches of idling on one, both or neither side;
            // the tail of the run streams at full rate.
            if (i % 60 == 0) begin
                s_idle_on = 1'($urandom_range(0, 1));
                m_idle_on = 1'($urandom_range(0, 1));
            end
            if (i >= n_rand - 80) begin
                s_idle_on = 1'b0;
                m_idle_on = 1'b0;
            end
            case ($urandom_range(0, 7))
                0: base = 32'h0000_0000;
                1: base = 32'hFFFF_FFFF - 32'($urandom_range(0, 64));
                2: base = 32'($urandom_range(0, 64));
                default: base = $urandom;
            endcase
            case ($urandom_range(0, 9))
                0: list = 16'h0000;
                1: list = 16'hFFFF;
                2: list = 16'h1 << $urandom_range(0, 15);
                3: list = 16'($urandom) & 16'($urandom);
                default: list = 16'($urandom);
            endcase
            flags = 4'($urandom);
            send_instr(pack_instr(base, 4'($urandom), list, flags[0], flags[1],
                                  flags[2], flags[3]));
        end
        s_tvalid = 1'b0;

        while (sb.pending_xfers.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);

        $display("Ran %0d instructions (%0d with no output) through every addressing mode.",
                 sb.n_instr, sb.n_empty);
        $display("Checked %0d transfer commands and %0d base updates under random stalls.",
                 sb.n_xfer, sb.n_update);
        if (sb.n_errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

`default_nettype wire

FILE: files.f
sv/lsms_pkg.sv
sv/load_store_multiple_sequencer.sv
sv/lsms_checker.sv
sim/tb.sv
